// ===== rtl/core/tdp_pkg.sv =====
// tdp_pkg: shared constants, sequencer state type and verdict struct
// for the trial-division prime tester. No dependencies.
`timescale 1ns / 1ps

package tdp_pkg;

    // Default width of the candidate value
    localparam int VALUE_BITS_DEF = 31;

    // First trial divisor
    localparam int FIRST_DIVISOR = 2;

    // Sequencer states
    typedef enum logic [1:0] {
        TDP_IDLE,
        TDP_DIV,
        TDP_REPORT
    } tdp_state_t;

    // Sequencer to output stage: finished verdict
    typedef struct packed {
        logic done;
        logic prime;
    } tdp_verdict_t;

endpackage

// ===== rtl/core/tdp_cand_if.sv =====
// tdp_cand_if: valid/ready channel carrying one candidate value per beat.
// Depends on tdp_pkg for the default width.
`timescale 1ns / 1ps

interface tdp_cand_if #(
    parameter int VALUE_BITS = tdp_pkg::VALUE_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic [VALUE_BITS-1:0] candidate;

    modport source (output valid, output candidate, input ready);
    modport sink   (input valid, input candidate, output ready);
endinterface

// ===== rtl/core/tdp_result_if.sv =====
// tdp_result_if: valid/ready channel carrying one prime flag per beat.
// No dependencies.
`timescale 1ns / 1ps

interface tdp_result_if;
    logic valid;
    logic ready;
    logic prime_flag;

    modport source (output valid, output prime_flag, input ready);
    modport sink   (input valid, input prime_flag, output ready);
endinterface

// ===== rtl/core/trial_division_prime_test.sv =====
// Channel  | Dir | Payload                       | Notes
// ---------+-----+-------------------------------+-------------------------------
// cand     | in  | candidate [VALUE_BITS-1:0]    | one value per beat
// result   | out | prime_flag                    | one beat per candidate
//
// One candidate at a time. Each trial divisor costs one pass of the
// bit-serial divider; a prime v takes floor(sqrt(v)) trials (the last one
// finds the divisor past the square root), a composite stops at its smallest
// factor. Values 0 and 1 take no trial division.
// Reset is asynchronous, active low, and clears control state only. A stalled
// result sits in the output register while the next candidate is already
// accepted and divided.
//
// trial_division_prime_test: top level. Uses tdp_pkg, tdp_cand_if,
// tdp_result_if, tdp_div and tdp_seq.
`timescale 1ns / 1ps

module trial_division_prime_test #(
    parameter int VALUE_BITS = tdp_pkg::VALUE_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    tdp_cand_if.sink      cand,
    tdp_result_if.source  result
);
    tdp_pkg::tdp_verdict_t verdict;

    logic                  slot_free;
    logic                  div_start;
    logic                  div_done;
    logic [VALUE_BITS-1:0] div_dividend;
    logic [VALUE_BITS-1:0] div_divisor;
    logic [VALUE_BITS-1:0] div_quotient;
    logic [VALUE_BITS-1:0] div_remainder;

    logic out_valid_reg, out_valid_next;
    logic flag_reg, flag_next;

    tdp_seq #(
        .VALUE_BITS (VALUE_BITS)
    ) u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .cand_valid    (cand.valid),
        .cand_ready    (cand.ready),
        .candidate     (cand.candidate),
        .slot_free     (slot_free),
        .verdict       (verdict),
        .div_start     (div_start),
        .div_dividend  (div_dividend),
        .div_divisor   (div_divisor),
        .div_done      (div_done),
        .div_quotient  (div_quotient),
        .div_remainder (div_remainder)
    );

    tdp_div #(
        .W (VALUE_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quotient),
        .remainder (div_remainder)
    );

    // Output register: free when empty or being drained this cycle
    assign slot_free = !out_valid_reg || result.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        flag_next      = flag_reg;
        if (verdict.done && slot_free)
        begin
            out_valid_next = 1'b1;
            flag_next      = verdict.prime;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        flag_reg <= flag_next;
    end

    assign result.valid      = out_valid_reg;
    assign result.prime_flag = flag_reg;

endmodule

// ===== rtl/core/tdp_div.sv =====
// tdp_div: bit-serial restoring divider, one quotient bit per cycle.
// Latches the dividend on start; divisor must stay stable while busy.
`timescale 1ns / 1ps

module tdp_div #(
    parameter int W = tdp_pkg::VALUE_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic         done,
    output logic [W-1:0] quotient,
    output logic [W-1:0] remainder
);
    localparam int CW = (W > 1) ? $clog2(W) : 1;

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [W-1:0]  quo_reg, quo_next;
    logic [W-1:0]  rem_reg, rem_next;

    logic [W:0]    trial;
    logic          ge;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    assign trial = {rem_reg, quo_reg[W-1]};
    assign ge    = (trial >= {1'b0, divisor});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(W - 1);
            quo_next  = dividend;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[W-2:0], ge};
            rem_next = ge ? W'(trial - {1'b0, divisor}) : trial[W-1:0];
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Shift registers
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// ===== rtl/core/tdp_seq.sv =====
// tdp_seq: trial-divisor sequencer. Steps the divisor from 2 and runs
// one serial division per divisor. Depends on tdp_pkg.
`timescale 1ns / 1ps

module tdp_seq #(
    parameter int VALUE_BITS = tdp_pkg::VALUE_BITS_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cand_valid,
    output logic                    cand_ready,
    input  logic [VALUE_BITS-1:0]   candidate,
    input  logic                    slot_free,
    output tdp_pkg::tdp_verdict_t   verdict,
    output logic                    div_start,
    output logic [VALUE_BITS-1:0]   div_dividend,
    output logic [VALUE_BITS-1:0]   div_divisor,
    input  logic                    div_done,
    input  logic [VALUE_BITS-1:0]   div_quotient,
    input  logic [VALUE_BITS-1:0]   div_remainder
);
    localparam logic [VALUE_BITS-1:0] FIRST_D = VALUE_BITS'(tdp_pkg::FIRST_DIVISOR);

    tdp_pkg::tdp_state_t     state_reg, state_next;
    logic [VALUE_BITS-1:0]   value_reg, value_next;
    logic [VALUE_BITS-1:0]   d_reg, d_next;
    logic                    prime_reg, prime_next;

    // Next state and outputs
    always_comb
    begin
        state_next   = state_reg;
        value_next   = value_reg;
        d_next       = d_reg;
        prime_next   = prime_reg;
        cand_ready   = 1'b0;
        div_start    = 1'b0;
        div_dividend = value_reg;
        verdict.done  = 1'b0;
        verdict.prime = prime_reg;
        case (state_reg)
            tdp_pkg::TDP_IDLE:
            begin
                cand_ready   = 1'b1;
                div_dividend = candidate;
                if (cand_valid)
                begin
                    value_next = candidate;
                    d_next     = FIRST_D;
                    if (candidate < FIRST_D)
                    begin
                        // zero and one are not prime
                        prime_next = 1'b0;
                        state_next = tdp_pkg::TDP_REPORT;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = tdp_pkg::TDP_DIV;
                    end
                end
            end
            tdp_pkg::TDP_DIV:
            begin
                if (div_done)
                begin
                    if (d_reg > div_quotient)
                    begin
                        // d*d exceeds value: no divisor found
                        prime_next = 1'b1;
                        state_next = tdp_pkg::TDP_REPORT;
                    end
                    else if (div_remainder == '0)
                    begin
                        prime_next = 1'b0;
                        state_next = tdp_pkg::TDP_REPORT;
                    end
                    else
                    begin
                        d_next    = d_reg + VALUE_BITS'(1);
                        div_start = 1'b1;
                    end
                end
            end
            tdp_pkg::TDP_REPORT:
            begin
                verdict.done = 1'b1;
                if (slot_free)
                begin
                    state_next = tdp_pkg::TDP_IDLE;
                end
            end
            default:
            begin
                state_next = tdp_pkg::TDP_IDLE;
            end
        endcase
    end

    assign div_divisor = d_reg;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tdp_pkg::TDP_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        d_reg     <= d_next;
        prime_reg <= prime_next;
    end

endmodule

// ===== dv/trial_division_prime_test_test.sv =====
// trial_division_prime_test_test: self-checking bench for the trial-division prime tester.
// Drives candidates over tdp_cand_if and checks each prime flag against a software trial division.
// Depends on tdp_pkg, tdp_cand_if, tdp_result_if and the trial_division_prime_test RTL.
`timescale 1ns / 1ps

module trial_division_prime_test_test;

    localparam int VALUE_BITS = tdp_pkg::VALUE_BITS_DEF;
    localparam longint VALUE_MAX = (longint'(1) << VALUE_BITS) - 1;
    localparam int MAX_REPORTS = 10;

    logic clk;
    logic rst_n;

    tdp_cand_if #(.VALUE_BITS(VALUE_BITS)) cand_ch();
    tdp_result_if res_ch();

    trial_division_prime_test #(
        .VALUE_BITS(VALUE_BITS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cand(cand_ch),
        .result(res_ch)
    );

    // Flags still owed by the block, oldest first
    logic [VALUE_BITS-1:0] pending_cands[$];
    bit                    pending_flags[$];

    int error_count;
    int send_idle_pct;
    int recv_idle_pct;

    // 100 MHz clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Watchdog: far beyond the slowest legal run (one 31-bit prime plus small randoms)
    initial
    begin
        #400_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Trial division on the masked value; d <= v / d avoids overflow in d * d
    function automatic bit trial_primality(input logic [VALUE_BITS-1:0] value);
        longint unsigned v;
        longint unsigned d;
        v = longint'(value);
        if (v < tdp_pkg::FIRST_DIVISOR)
            return 1'b0;
        for (d = tdp_pkg::FIRST_DIVISOR; d <= v / d; d++)
        begin
            if (v % d == 0)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // Result sink: random backpressure
    always @(negedge clk)
    begin
        res_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Result checker: compare every accepted beat with the oldest pending flag
    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (pending_flags.size() == 0)
            begin
                if (error_count < MAX_REPORTS)
                    $display("%0t: unexpected result beat, prime_flag=%0b",
                             $realtime, res_ch.prime_flag);
                error_count++;
            end
            else
            begin
                logic [VALUE_BITS-1:0] cand_val;
                bit                    want;
                cand_val = pending_cands.pop_front();
                want     = pending_flags.pop_front();
                if (res_ch.prime_flag !== want)
                begin
                    if (error_count < MAX_REPORTS)
                        $display("%0t: candidate %0d prime_flag expected %0b actual %0b",
                                 $realtime, cand_val, want, res_ch.prime_flag);
                    error_count++;
                end
            end
        end
    end

    // Send one candidate beat; called and returns at a falling edge
    task automatic send_candidate(input logic [VALUE_BITS-1:0] value);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            cand_ch.valid <= 1'b0;
            @(negedge clk);
        end
        cand_ch.valid     <= 1'b1;
        cand_ch.candidate <= value;
        @(posedge clk);
        while (!cand_ch.ready)
            @(posedge clk);
        pending_cands.push_back(value);
        pending_flags.push_back(trial_primality(value));
        @(negedge clk);
    endtask

    // Hold off the sender until every owed flag has come back
    task automatic drain_results();
        cand_ch.valid <= 1'b0;
        while (pending_flags.size() != 0)
            @(negedge clk);
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
    endtask

    // Zero and one are not prime, two and three take a single trial, small composites
    task automatic test_tiny_values();
        int v;
        for (v = 0; v <= 8; v++)
            send_candidate(VALUE_BITS'(v));
    endtask

    // Perfect squares must be composite: the bound includes the square root; also 1021*1031 and the prime 65521
    task automatic test_perfect_squares();
        send_candidate(VALUE_BITS'(9));
        send_candidate(VALUE_BITS'(25));
        send_candidate(VALUE_BITS'(49));
        send_candidate(VALUE_BITS'(121));
        send_candidate(VALUE_BITS'(251 * 251));
        send_candidate(VALUE_BITS'(1021 * 1031));
        send_candidate(VALUE_BITS'(65521));
    endtask

    // Top of the field: the all-ones value is prime and the slowest case
    task automatic test_field_extremes();
        send_candidate(VALUE_BITS'(VALUE_MAX));
        send_candidate(VALUE_BITS'(VALUE_MAX - 1));
        send_candidate(VALUE_BITS'(VALUE_MAX - 2));
        send_candidate(VALUE_BITS'(longint'(1) << (VALUE_BITS - 1)));
        send_candidate(31'h5555_5555);
        send_candidate(31'h2AAA_AAAA);
    endtask

    // Random candidates: mostly small, some mid-size, some large with a small factor
    task automatic test_random_candidates(input int count);
        int              i;
        int              pick;
        longint unsigned fac;
        longint unsigned mult;
        logic [VALUE_BITS-1:0] value;
        for (i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
                value = VALUE_BITS'($urandom_range(0, 4095));
            else if (pick < 80)
                value = VALUE_BITS'($urandom_range(4096, 1 << 20));
            else
            begin
                // keeps upper bits busy without a long trial run
                fac   = 64'($urandom_range(2, 97));
                mult  = 64'($urandom_range(int'(VALUE_MAX / (2 * fac)),
                                           int'(VALUE_MAX / fac)));
                value = VALUE_BITS'(fac * mult);
            end
            send_candidate(value);
        end
    endtask

    // Test sequence
    initial
    begin
        error_count       = 0;
        send_idle_pct     = 35;
        recv_idle_pct     = 66;
        rst_n             = 1'b0;
        cand_ch.valid     = 1'b0;
        cand_ch.candidate = '0;
        res_ch.ready      = 1'b0;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        set_idling(35, 66);
        test_tiny_values();
        test_perfect_squares();
        drain_results();
        test_field_extremes();
        test_random_candidates(34);
        drain_results();

        set_idling(66, 35);
        test_random_candidates(33);

        set_idling(0, 0);
        test_random_candidates(33);
        drain_results();

        // Let any trailing activity settle
        repeat (2 * VALUE_BITS + 8) @(posedge clk);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
